@@ rtl/core/fba_pkg.sv @@
// Shared constants, request kinds and controller/datapath interface structs
// for the frame bitmap allocator. No dependencies.
package fba_pkg;

	localparam int FRAME_W     = 20;
	localparam int FRAMES      = 1 << FRAME_W;
	localparam int CNT_W       = 21;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = 6;
	localparam int WORDS       = FRAMES / WORD_W;
	localparam int WADDR_W     = FRAME_W - BIT_W;
	localparam int PAGE_SHIFT  = 12;
	localparam int ADDR_W      = 32;
	localparam int LARGE_SHIFT = 9;
	localparam int HUGE_SHIFT  = 18;
	localparam int TOTAL_W     = CNT_W + HUGE_SHIFT + 1;

	typedef enum logic [2:0] {
		KIND_ALLOC_FRAMES = 3'd0,
		KIND_ALLOC_LARGE  = 3'd1,
		KIND_ALLOC_HUGE   = 3'd2,
		KIND_FREE_FRAME   = 3'd3,
		KIND_FREE_LARGE   = 3'd4,
		KIND_FREE_HUGE    = 3'd5,
		KIND_MARK_FREE    = 3'd6,
		KIND_MARK_USED    = 3'd7
	} kind_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic clear_wr;
		logic scan_step;
		logic range_wr;
		logic count_upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic alloc_ok;
		logic range_nonzero;
		logic found;
		logic ptr_last;
		logic range_last;
	} sts_t;

endpackage

@@ rtl/core/fba_ram.sv @@
// Generic single-port RAM, registered read (read-old on write).
// No dependencies.
module fba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/core/fba_dp.sv @@
// Datapath: request registers, bitmap RAM, word scan logic, range
// read-modify-write, free counter and result registers. Uses fba_pkg, fba_ram.
module fba_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fba_pkg::cmd_t                      cmd,
	output fba_pkg::sts_t                      sts,
	input  logic [2:0]                         kind,
	input  logic [fba_pkg::ADDR_W-1:0]         byte_address,
	input  logic [fba_pkg::CNT_W-1:0]          count,
	output logic                               granted,
	output logic [fba_pkg::ADDR_W-1:0]         result_address,
	output logic [fba_pkg::CNT_W-1:0]          free_frames
);

	localparam logic [fba_pkg::CNT_W-1:0] FRAMES_C = fba_pkg::CNT_W'(fba_pkg::FRAMES);

	fba_pkg::kind_t                    kind_q;
	logic [fba_pkg::FRAME_W-1:0]       frame_q;
	logic [fba_pkg::CNT_W-1:0]         count_q;
	logic [fba_pkg::CNT_W-1:0]         total_q;
	logic [fba_pkg::WADDR_W-1:0]       ptr_q;
	logic [fba_pkg::CNT_W-1:0]         run_len_q;
	logic [fba_pkg::FRAME_W-1:0]       run_start_q;
	logic [fba_pkg::FRAME_W-1:0]       start_q;
	logic [fba_pkg::FRAME_W-1:0]       lo_q;
	logic [fba_pkg::CNT_W-1:0]         hi_q;
	logic [fba_pkg::CNT_W-1:0]         n_q;
	logic                              val_q;
	logic                              add_q;
	logic                              granted_q;
	logic [fba_pkg::CNT_W-1:0]         cnt_q;

	logic                              ram_we;
	logic [fba_pkg::WORD_W-1:0]        ram_wdata;
	logic [fba_pkg::WORD_W-1:0]        rdata;

	fba_ram #(
		.WIDTH(fba_pkg::WORD_W),
		.DEPTH(fba_pkg::WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.addr (ptr_q),
		.wdata(ram_wdata),
		.rdata(rdata)
	);

	// decode of the held request
	logic [fba_pkg::TOTAL_W-1:0]  total_w;
	logic                         is_alloc, alloc_ok, is_free_kind;
	logic [fba_pkg::CNT_W-1:0]    len, room, n_dec;

	always_comb begin
		is_alloc = (kind_q == fba_pkg::KIND_ALLOC_FRAMES) ||
		           (kind_q == fba_pkg::KIND_ALLOC_LARGE) ||
		           (kind_q == fba_pkg::KIND_ALLOC_HUGE);
		is_free_kind = (kind_q == fba_pkg::KIND_FREE_FRAME) ||
		               (kind_q == fba_pkg::KIND_FREE_LARGE) ||
		               (kind_q == fba_pkg::KIND_FREE_HUGE);
		case (kind_q)
			fba_pkg::KIND_ALLOC_LARGE: total_w = fba_pkg::TOTAL_W'(count_q) << fba_pkg::LARGE_SHIFT;
			fba_pkg::KIND_ALLOC_HUGE:  total_w = fba_pkg::TOTAL_W'(count_q) << fba_pkg::HUGE_SHIFT;
			default:                   total_w = fba_pkg::TOTAL_W'(count_q);
		endcase
		alloc_ok = (total_w != '0) && (total_w <= fba_pkg::TOTAL_W'(fba_pkg::FRAMES));
		case (kind_q)
			fba_pkg::KIND_FREE_FRAME: len = fba_pkg::CNT_W'(1);
			fba_pkg::KIND_FREE_LARGE: len = fba_pkg::CNT_W'(1) << fba_pkg::LARGE_SHIFT;
			fba_pkg::KIND_FREE_HUGE:  len = fba_pkg::CNT_W'(1) << fba_pkg::HUGE_SHIFT;
			default:                  len = count_q;
		endcase
		room = FRAMES_C - {1'b0, frame_q};
		n_dec = (len < room) ? len : room;
		if (is_free_kind && frame_q == '0) begin
			n_dec = '0;
		end
	end

	// word scan
	logic [fba_pkg::FRAME_W-1:0] base, run_eff_start, found_start, nxt_start;
	logic                        all_ones, aligned, is_frames, hit_a, hit_b;
	logic [6:0]                  tzo, lead, gain;
	logic [fba_pkg::CNT_W:0]     sum_a;
	logic [fba_pkg::WORD_W-1:0]  mask_l;
	logic [fba_pkg::BIT_W-1:0]   p_b;
	logic [fba_pkg::CNT_W-1:0]   nxt_len;

	always_comb begin
		base = {ptr_q, {fba_pkg::BIT_W{1'b0}}};
		all_ones = &rdata;
		is_frames = (kind_q == fba_pkg::KIND_ALLOC_FRAMES);
		aligned = (kind_q == fba_pkg::KIND_ALLOC_LARGE) ?
		          (base[fba_pkg::LARGE_SHIFT-1:0] == '0) :
		          (base[fba_pkg::HUGE_SHIFT-1:0] == '0);
		tzo = 7'd64;
		for (int i = fba_pkg::WORD_W - 1; i >= 0; i--) begin
			if (!rdata[i]) tzo = 7'(i);
		end
		lead = 7'd64;
		for (int i = 0; i < fba_pkg::WORD_W; i++) begin
			if (!rdata[i]) lead = 7'(fba_pkg::WORD_W - 1 - i);
		end
		run_eff_start = (run_len_q == '0) ? base : run_start_q;
		if (is_frames) begin
			gain = tzo;
		end else begin
			gain = (all_ones && (run_len_q != '0 || aligned)) ? 7'd64 : 7'd0;
		end
		sum_a = {1'b0, run_len_q} + (fba_pkg::CNT_W + 1)'(gain);
		hit_a = (gain != '0) && (sum_a >= {1'b0, total_q});

		// run of total ones wholly inside this word, lowest start
		mask_l = (total_q >= fba_pkg::CNT_W'(64)) ? '1 :
		         ((fba_pkg::WORD_W'(1) << total_q[fba_pkg::BIT_W-1:0]) - fba_pkg::WORD_W'(1));
		hit_b = 1'b0;
		p_b = '0;
		for (int p = fba_pkg::WORD_W - 1; p >= 0; p--) begin
			if (is_frames && (fba_pkg::CNT_W'(p) + total_q <= fba_pkg::CNT_W'(64)) &&
			    (((rdata >> p) & mask_l) == mask_l)) begin
				hit_b = 1'b1;
				p_b = fba_pkg::BIT_W'(p);
			end
		end
		found_start = hit_a ? run_eff_start : (base + fba_pkg::FRAME_W'(p_b));

		if (is_frames && !all_ones) begin
			nxt_len = fba_pkg::CNT_W'(lead);
			nxt_start = base + fba_pkg::FRAME_W'(7'd64 - lead);
		end else if (gain == 7'd64) begin
			nxt_len = run_len_q + fba_pkg::CNT_W'(64);
			nxt_start = run_eff_start;
		end else begin
			nxt_len = '0;
			nxt_start = base;
		end
	end

	// range word update
	logic [fba_pkg::WORD_W-1:0]  wmask, new_word;
	logic [fba_pkg::CNT_W-1:0]   fidx, hi_m1;

	always_comb begin
		for (int b = 0; b < fba_pkg::WORD_W; b++) begin
			fidx = {1'b0, ptr_q, fba_pkg::BIT_W'(b)};
			wmask[b] = (fidx >= {1'b0, lo_q}) && (fidx < hi_q);
		end
		new_word = val_q ? (rdata | wmask) : (rdata & ~wmask);
		hi_m1 = hi_q - fba_pkg::CNT_W'(1);
		ram_we = cmd.clear_wr | cmd.range_wr;
		ram_wdata = cmd.clear_wr ? '0 : new_word;
	end

	assign sts.is_alloc      = is_alloc;
	assign sts.alloc_ok      = alloc_ok;
	assign sts.range_nonzero = (n_dec != '0);
	assign sts.found         = hit_a | hit_b;
	assign sts.ptr_last      = (ptr_q == fba_pkg::WADDR_W'(fba_pkg::WORDS - 1));
	assign sts.range_last    = (ptr_q == hi_m1[fba_pkg::FRAME_W-1:fba_pkg::BIT_W]);

	logic [fba_pkg::CNT_W:0] cnt_sum;
	assign cnt_sum = {1'b0, cnt_q} + {1'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			cnt_q     <= '0;
			granted_q <= 1'b0;
			run_len_q <= '0;
		end else begin
			if (cmd.decode) begin
				granted_q <= 1'b0;
				run_len_q <= '0;
				ptr_q <= is_alloc ? '0 : frame_q[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
			end
			if (cmd.clear_wr || cmd.range_wr) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.scan_step) begin
				if (hit_a || hit_b) begin
					granted_q <= 1'b1;
					ptr_q <= found_start[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
				end else begin
					run_len_q <= nxt_len;
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (cmd.count_upd) begin
				if (add_q) begin
					cnt_q <= (cnt_sum > {1'b0, FRAMES_C}) ? FRAMES_C : cnt_sum[fba_pkg::CNT_W-1:0];
				end else begin
					cnt_q <= (n_q >= cnt_q) ? '0 : (cnt_q - n_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= fba_pkg::kind_t'(kind);
			frame_q <= byte_address[fba_pkg::ADDR_W-1:fba_pkg::PAGE_SHIFT];
			count_q <= count;
		end
		if (cmd.decode) begin
			total_q <= total_w[fba_pkg::CNT_W-1:0];
			lo_q    <= frame_q;
			hi_q    <= {1'b0, frame_q} + n_dec;
			n_q     <= is_alloc ? '0 : n_dec;
			// allocations and mark used clear bits, frees and mark free set them
			val_q   <= !is_alloc && (kind_q != fba_pkg::KIND_MARK_USED);
			add_q   <= !is_alloc && (kind_q != fba_pkg::KIND_MARK_USED);
		end
		if (cmd.scan_step) begin
			if (hit_a || hit_b) begin
				start_q <= found_start;
				lo_q    <= found_start;
				hi_q    <= {1'b0, found_start} + total_q;
				n_q     <= total_q;
			end else begin
				run_start_q <= nxt_start;
			end
		end
		if (cmd.out_load) begin
			granted        <= granted_q;
			result_address <= granted_q ? {start_q, {fba_pkg::PAGE_SHIFT{1'b0}}} : '0;
			free_frames    <= cnt_q;
		end
	end

endmodule

@@ rtl/core/fba_ctrl.sv @@
// Controller state machine: sequences clear pass, scan, range update,
// counter update and result hand-off. Uses fba_pkg.
module fba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  fba_pkg::sts_t sts,
	output fba_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_DECODE, ST_SCAN_RD, ST_SCAN_EV,
		ST_RANGE_RD, ST_RANGE_WR, ST_COUNT
	} state_t;

	state_t state_q, state_d;
	logic   done_q, out_valid_q;
	logic   can_out;

	assign can_out   = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || done_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.ptr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (done_q) begin
					if (can_out) cmd.out_load = 1'b1;
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.is_alloc) begin
					state_d = sts.alloc_ok ? ST_SCAN_RD : ST_COUNT;
				end else begin
					state_d = sts.range_nonzero ? ST_RANGE_RD : ST_COUNT;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: begin
				cmd.scan_step = 1'b1;
				if (sts.found) state_d = ST_RANGE_RD;
				else if (sts.ptr_last) state_d = ST_COUNT;
				else state_d = ST_SCAN_RD;
			end
			ST_RANGE_RD: state_d = ST_RANGE_WR;
			ST_RANGE_WR: begin
				cmd.range_wr = 1'b1;
				state_d = sts.range_last ? ST_COUNT : ST_RANGE_RD;
			end
			ST_COUNT: begin
				cmd.count_upd = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_COUNT) begin
				done_q <= 1'b1;
			end else if (cmd.out_load) begin
				done_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/frame_bitmap_allocator.sv @@
// Top level of the frame bitmap allocator: controller plus datapath.
// Uses fba_pkg, fba_ctrl, fba_dp (which holds the fba_ram bitmap).
//
// Usage:
//  - Request channel (in_valid/in_stall, kind, byte_address, count) and
//    result channel (out_valid/out_stall, granted, result_address,
//    free_frames); a request or result moves when valid is high and stall low.
//  - One request is processed at a time; every request yields one result.
//  - The bitmap lives in a 16384 x 64 single-port RAM, one word per 64
//    frames; the RAM port sets the cost: each word read or updated takes a
//    read state and an evaluate or write state. A request that touches no
//    frame passes decode and counter update, then its result is loaded and
//    out_valid rises; a new request can be taken after that load. Allocations
//    scan words from frame 0 until the run is found, then update each word
//    of the run; free and mark requests update each bitmap word covered.
//  - After reset a clearing pass writes every word to "used", with in_stall
//    high; the free counter starts at zero.
//  - The result sits in an output register. If the receiver stalls, the
//    next request may finish its work but its result waits (and the
//    request channel stalls) until the earlier result is taken.
module frame_bitmap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  kind,
	input  logic [fba_pkg::ADDR_W-1:0]  byte_address,
	input  logic [fba_pkg::CNT_W-1:0]   count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        granted,
	output logic [fba_pkg::ADDR_W-1:0]  result_address,
	output logic [fba_pkg::CNT_W-1:0]   free_frames
);

	fba_pkg::cmd_t cmd;
	fba_pkg::sts_t sts;

	fba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.byte_address  (byte_address),
		.count         (count),
		.granted       (granted),
		.result_address(result_address),
		.free_frames   (free_frames)
	);

endmodule

@@ verif/frame_bitmap_allocator_test.sv @@
// Self-checking testbench for the frame bitmap allocator top level.
// Depends on fba_pkg and frame_bitmap_allocator; holds its own bitmap predictor.
`timescale 1ns / 100ps

module frame_bitmap_allocator_test;
	import fba_pkg::*;

	localparam int  RANDOM_REQS  = 1880;
	localparam int  FAIL_BUDGET  = 8;        // each failed alloc scans the whole map
	localparam int  REGION       = 4096;     // frames the random traffic lives in
	localparam int  WATCHDOG_MAX = 200000;   // > clear pass, full scan, long stalls

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        kind;
	logic [ADDR_W-1:0] byte_address;
	logic [CNT_W-1:0]  count;
	logic              out_valid;
	logic              out_stall;
	logic              granted;
	logic [ADDR_W-1:0] result_address;
	logic [CNT_W-1:0]  free_frames;

	frame_bitmap_allocator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.byte_address   (byte_address),
		.count          (count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted        (granted),
		.result_address (result_address),
		.free_frames    (free_frames)
	);

	// One expected result per request, oldest first.
	typedef struct {
		logic              g;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  frames;
	} grant_t;

	// Directed request row; typed=1 means the expected result is given in the row.
	typedef struct {
		kind_t             k;
		logic [ADDR_W-1:0] a;
		logic [CNT_W-1:0]  c;
		bit                typed;
		grant_t            res;
	} dir_row_t;

	grant_t   pending_grants[$];
	dir_row_t dir_rows[$];
	int       mismatches;
	int       alloc_fails;
	int       stall_quiet;   // receiver runs without stalls when set
	int       send_quiet;    // sender runs without gaps when set

	// ---------------------------------------------------------------
	// Predictor state: bitmap words (1 = free) and the usable counter.
	// ---------------------------------------------------------------
	logic [WORD_W-1:0] shadow_map [WORDS];
	longint            shadow_usable;

	function automatic bit shadow_free(longint f);
		if (f >= FRAMES)
			return 1'b0;
		return shadow_map[f >> 6][f & 63];
	endfunction

	// Set or clear [lo, hi), whole words at a time where aligned.
	task automatic shadow_write(longint lo, longint hi, bit v);
		longint f;
		if (hi > FRAMES)
			hi = FRAMES;
		f = lo;
		while (f < hi) begin
			if ((f & 63) == 0 && f + 64 <= hi) begin
				shadow_map[f >> 6] = v ? '1 : '0;
				f += 64;
			end else begin
				shadow_map[f >> 6][f & 63] = v;
				f += 1;
			end
		end
	endtask

	function automatic longint clip_len(longint lo, longint len);
		longint hi;
		if (lo >= FRAMES)
			return 0;
		hi = lo + len;
		if (hi > FRAMES)
			hi = FRAMES;
		return hi - lo;
	endfunction

	// First fit over starts that are multiples of step. Skips the rest of a
	// word once it holds no more free frames, which leaves the answer unchanged.
	function automatic bit first_fit(longint step, longint total, output longint start);
		longint i, j, stop;
		logic [WORD_W-1:0] w;
		start = 0;
		if (total == 0 || total > FRAMES)
			return 1'b0;
		i = 0;
		while (i + total <= FRAMES) begin
			j = i;
			stop = i + total;
			while (j < stop) begin
				if ((j & 63) == 0 && j + 64 <= stop && shadow_map[j >> 6] == '1)
					j += 64;
				else if (shadow_free(j))
					j += 1;
				else
					break;
			end
			if (j == stop) begin
				start = i;
				return 1'b1;
			end
			w = shadow_map[j >> 6] >> (j & 63);
			if (w == '0)
				j = j | 63;
			i = (j / step + 1) * step;
		end
		return 1'b0;
	endfunction

	function automatic longint block_step(kind_t k);
		case (k)
			KIND_ALLOC_LARGE, KIND_FREE_LARGE: return longint'(1) << LARGE_SHIFT;
			KIND_ALLOC_HUGE, KIND_FREE_HUGE:   return longint'(1) << HUGE_SHIFT;
			default:                           return 1;
		endcase
	endfunction

	task automatic usable_add(longint n);
		shadow_usable += n;
		if (shadow_usable > FRAMES)
			shadow_usable = FRAMES;
	endtask

	task automatic usable_sub(longint n);
		if (n >= shadow_usable)
			shadow_usable = 0;
		else
			shadow_usable -= n;
	endtask

	// Apply one request to the shadow state and return its result.
	task automatic predict_grant(kind_t k, logic [ADDR_W-1:0] a, logic [CNT_W-1:0] c,
			output grant_t r);
		longint frame, st, total, n;
		frame = a >> PAGE_SHIFT;
		r.g = 1'b0;
		r.addr = '0;
		case (k)
			KIND_ALLOC_FRAMES, KIND_ALLOC_LARGE, KIND_ALLOC_HUGE: begin
				total = longint'(c) * block_step(k);
				if (first_fit(block_step(k), total, st)) begin
					shadow_write(st, st + total, 1'b0);
					usable_sub(total);
					r.g = 1'b1;
					r.addr = ADDR_W'(st << PAGE_SHIFT);
				end
			end
			KIND_FREE_FRAME, KIND_FREE_LARGE, KIND_FREE_HUGE: begin
				// frame zero is never handed back
				if (frame != 0) begin
					n = clip_len(frame, block_step(k));
					shadow_write(frame, frame + n, 1'b1);
					usable_add(n);
				end
			end
			default: begin
				n = clip_len(frame, longint'(c));
				shadow_write(frame, frame + n, k == KIND_MARK_FREE);
				if (k == KIND_MARK_FREE)
					usable_add(n);
				else
					usable_sub(n);
			end
		endcase
		r.frames = CNT_W'(shadow_usable);
	endtask

	task automatic report_mismatch(string field, longint got, longint want);
		$display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", field, got, want, $time);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// Clock, reset, watchdog
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------
	// Result side: random stalls at the falling edge, check at the rising edge
	// ---------------------------------------------------------------
	initial begin
		int hold;
		out_stall = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (stall_quiet) begin
				out_stall = 1'b0;
			end else begin
				hold = pick_gap();
				out_stall = (hold > 0);
			end
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_grants.pop_front();
				if (granted !== want.g)
					report_mismatch("granted", granted, want.g);
				if (result_address !== want.addr)
					report_mismatch("result_address", result_address, want.addr);
				if (free_frames !== want.frames)
					report_mismatch("free_frames", free_frames, want.frames);
			end
		end
	end

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------
	// Drives one request from the falling edge, holds it until taken, then
	// queues either the typed result or the predictor's. Leaves valid high;
	// the caller's gap (if any) drops it.
	task automatic send_request(kind_t k, logic [ADDR_W-1:0] a, logic [CNT_W-1:0] c,
			bit typed, grant_t typed_res);
		grant_t r;
		in_valid = 1'b1;
		kind = k;
		byte_address = a;
		count = c;
		do
			@(posedge clk);
		while (in_stall);
		predict_grant(k, a, c, r);
		if (!r.g && k inside {KIND_ALLOC_FRAMES, KIND_ALLOC_LARGE, KIND_ALLOC_HUGE})
			alloc_fails++;
		pending_grants.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = send_quiet ? 0 : pick_gap();
		if (g > 0) begin
			in_valid = 1'b0;
			kind = 3'($urandom);
			byte_address = $urandom;
			count = CNT_W'($urandom);
			repeat (g) @(negedge clk);
		end
	endtask

	// Random request aimed at the low region, where allocations mostly hit.
	task automatic pick_request(output kind_t k, output logic [ADDR_W-1:0] a,
			output logic [CNT_W-1:0] c);
		int r;
		longint st;
		r = $urandom_range(0, 999);
		a = {20'($urandom_range(1, REGION - 1)), 12'($urandom)};
		c = CNT_W'($urandom_range(1, 64));
		if (r < 300) begin
			k = KIND_ALLOC_FRAMES;
			if ($urandom_range(0, 19) == 0)
				c = CNT_W'($urandom_range(0, 300));
		end else if (r < 400) begin
			k = KIND_ALLOC_LARGE;
			c = CNT_W'($urandom_range(0, 3));
		end else if (r < 405) begin
			k = KIND_ALLOC_HUGE;
			c = CNT_W'($urandom_range(1, 2));
		end else if (r < 560) begin
			k = KIND_FREE_FRAME;
			if ($urandom_range(0, 4) == 0)
				a = $urandom;
		end else if (r < 640) begin
			k = KIND_FREE_LARGE;
			if ($urandom_range(0, 4) == 0)
				a = $urandom;
		end else if (r < 645) begin
			k = KIND_FREE_HUGE;
			a = $urandom;
		end else if (r < 820) begin
			k = KIND_MARK_FREE;
			c = CNT_W'($urandom_range(0, 200));
		end else if (r < 940) begin
			k = KIND_MARK_USED;
			c = CNT_W'($urandom_range(0, 200));
		end else begin
			// top of the map with any count: clipped to a few words
			k = ($urandom_range(0, 1) != 0) ? KIND_MARK_FREE : KIND_MARK_USED;
			a = {12'hFFF, 8'($urandom), 12'($urandom)};
			c = CNT_W'($urandom);
		end
		// A failed allocation walks all 16384 words; keep them rare.
		if (k inside {KIND_ALLOC_FRAMES, KIND_ALLOC_LARGE, KIND_ALLOC_HUGE} &&
				alloc_fails >= FAIL_BUDGET &&
				!first_fit(block_step(k), longint'(c) * block_step(k), st)) begin
			k = KIND_MARK_FREE;
			a = {20'($urandom_range(1, 64)), 12'($urandom)};
			c = CNT_W'($urandom_range(64, 2048));
		end
	endtask

	initial begin
		kind_t             k;
		logic [ADDR_W-1:0] a;
		logic [CNT_W-1:0]  c;
		grant_t            none;

		in_valid = 1'b0;
		kind = KIND_ALLOC_FRAMES;
		byte_address = '0;
		count = '0;
		mismatches = 0;
		alloc_fails = 0;
		stall_quiet = 0;
		send_quiet = 0;
		shadow_usable = 0;
		none = '{1'b0, '0, '0};
		for (int w = 0; w < WORDS; w++)
			shadow_map[w] = '0;

		// After reset every frame is used, so early requests have plain answers.
		dir_rows.push_back('{KIND_ALLOC_FRAMES, 32'h0, 21'd1, 1, '{1'b0, 32'h0, 21'd0}});
		dir_rows.push_back('{KIND_ALLOC_FRAMES, 32'h0, 21'd0, 1, '{1'b0, 32'h0, 21'd0}});
		dir_rows.push_back('{KIND_ALLOC_HUGE, 32'h0, 21'd5, 1, '{1'b0, 32'h0, 21'd0}});
		dir_rows.push_back('{KIND_FREE_FRAME, 32'h0, 21'd0, 1, '{1'b0, 32'h0, 21'd0}});
		dir_rows.push_back('{KIND_FREE_HUGE, 32'h0000_0FFF, 21'h1FFFFF, 1,
			'{1'b0, 32'h0, 21'd0}});
		// whole map free, then the counter pinned at its ceiling
		dir_rows.push_back('{KIND_MARK_FREE, 32'h0, 21'h100000, 1,
			'{1'b0, 32'h0, 21'h100000}});
		dir_rows.push_back('{KIND_FREE_FRAME, 32'h0000_1000, 21'd0, 1,
			'{1'b0, 32'h0, 21'h100000}});
		// run starting at frame zero reports address zero with a grant
		dir_rows.push_back('{KIND_ALLOC_FRAMES, 32'hFFFF_FFFF, 21'd1, 1,
			'{1'b1, 32'h0, 21'h0FFFFF}});
		dir_rows.push_back('{KIND_ALLOC_FRAMES, 32'h0, 21'h100000, 0, none});
		dir_rows.push_back('{KIND_ALLOC_HUGE, 32'h0, 21'd1, 0, none});
		dir_rows.push_back('{KIND_ALLOC_LARGE, 32'h0, 21'd1, 0, none});
		dir_rows.push_back('{KIND_ALLOC_LARGE, 32'h0, 21'd0, 0, none});
		// whole map used, the counter floors at zero
		dir_rows.push_back('{KIND_MARK_USED, 32'h0, 21'h100000, 1, '{1'b0, 32'h0, 21'd0}});
		// clipping at the last frame
		dir_rows.push_back('{KIND_FREE_HUGE, 32'hFFFF_FFFF, 21'd0, 1, '{1'b0, 32'h0, 21'd1}});
		dir_rows.push_back('{KIND_FREE_LARGE, 32'hFFFF_F000, 21'd0, 1, '{1'b0, 32'h0, 21'd2}});
		dir_rows.push_back('{KIND_MARK_FREE, 32'hFFFF_F000, 21'h1FFFFF, 1,
			'{1'b0, 32'h0, 21'd3}});
		dir_rows.push_back('{KIND_MARK_USED, 32'h0, 21'd0, 0, none});
		dir_rows.push_back('{KIND_FREE_HUGE, 32'h4000_0000, 21'd0, 0, none});
		dir_rows.push_back('{KIND_ALLOC_HUGE, 32'h0, 21'd1, 0, none});
		dir_rows.push_back('{KIND_FREE_LARGE, 32'h0020_0000, 21'd0, 0, none});
		dir_rows.push_back('{KIND_ALLOC_LARGE, 32'h0, 21'd1, 0, none});
		dir_rows.push_back('{KIND_ALLOC_FRAMES, 32'h0, 21'd600, 0, none});
		// open the low region for the random traffic
		dir_rows.push_back('{KIND_MARK_FREE, 32'h0000_1000, 21'(REGION - 1), 0, none});

		@(posedge arst_n);
		@(negedge clk);
		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].k, dir_rows[i].a, dir_rows[i].c, dir_rows[i].typed,
				dir_rows[i].res);
			idle_gap();
		end

		for (int n = 0; n < RANDOM_REQS; n++) begin
			// alternate stretches with and without idling on either side
			if (n % 250 == 0) begin
				stall_quiet = ($urandom_range(0, 2) == 0);
				send_quiet = ($urandom_range(0, 2) == 0);
			end
			if (n == RANDOM_REQS / 2) begin
				// sender holds off until every result is back
				in_valid = 1'b0;
				while (pending_grants.size() != 0)
					@(negedge clk);
			end
			pick_request(k, a, c);
			send_request(k, a, c, 0, none);
			idle_gap();
		end
		in_valid = 1'b0;

		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0 && pending_grants.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/fba_pkg.sv
rtl/core/fba_ram.sv
rtl/core/fba_dp.sv
rtl/core/fba_ctrl.sv
rtl/core/frame_bitmap_allocator.sv
verif/frame_bitmap_allocator_test.sv
